/* rtl/lfcd_pkg.sv */
// Shared widths, register indexes and channel types of the cache directory.
package lfcd_pkg;

  localparam int ENTRIES_DEF  = 16;
  localparam int TAG_BITS_DEF = 32;

  localparam int HOST_W     = 32;
  localparam int PATH_W     = 32;
  localparam int PORT_W     = 16;
  localparam int SLOT_W     = 4;
  localparam int CAP_W      = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_REPLACE_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY     = 2'd1;

  localparam logic MODE_LRU  = 1'b0;
  localparam logic MODE_FIFO = 1'b1;

  localparam logic [CAP_W-1:0] CAPACITY_RST = 5'd16;

  typedef struct packed {
    logic             replace_mode;
    logic [CAP_W-1:0] capacity;
  } cfg_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              evicted;
    logic              stored;
  } result_t;

endpackage

/* rtl/lfcd_entry_ram.sv */
// Simple dual-port entry memory with registered read data.
module lfcd_entry_ram #(
  parameter int DEPTH  = lfcd_pkg::ENTRIES_DEF,
  parameter int WIDTH  = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/lfcd_ctrl.sv */
// Scan sequencer: walks the entry memory, applies the deferred rank update,
// finds hit / victim / free slot and writes the new entry.
module lfcd_ctrl #(
  parameter int ENTRIES  = lfcd_pkg::ENTRIES_DEF,
  parameter int TAG_BITS = lfcd_pkg::TAG_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lfcd_pkg::cfg_t              cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [lfcd_pkg::HOST_W-1:0] in_host_tag,
  input  logic [lfcd_pkg::PATH_W-1:0] in_path_tag,
  input  logic [lfcd_pkg::PORT_W-1:0] in_server_port,
  output logic                        res_valid,
  input  logic                        res_ready,
  output lfcd_pkg::result_t           res
);

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RANK_W = IDX_W;
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int CMP_W  = (CNT_W > lfcd_pkg::CAP_W) ? CNT_W : lfcd_pkg::CAP_W;
  localparam int TAG_W  = (TAG_BITS < lfcd_pkg::HOST_W) ? TAG_BITS : lfcd_pkg::HOST_W;
  localparam int KEY_W  = 2 * TAG_W + lfcd_pkg::PORT_W;
  localparam int WORD_W = KEY_W + RANK_W;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  // deferred rank update left by the previous item
  localparam logic [1:0] PK_NONE  = 2'd0;
  localparam logic [1:0] PK_ALL   = 2'd1;
  localparam logic [1:0] PK_BELOW = 2'd2;

  typedef struct packed {
    logic [1:0]        kind;
    logic [IDX_W-1:0]  slot;
    logic [RANK_W-1:0] thr;
  } pend_t;

  logic [1:0]         state_r;
  logic [KEY_W-1:0]   key_r;
  logic [ENTRIES-1:0] valid_r;
  logic [CNT_W-1:0]   live_r;
  pend_t              pend_r;

  logic [IDX_W-1:0]   rd_idx_r;
  logic               rd_done_r;
  logic               chk_vld_r;
  logic [IDX_W-1:0]   chk_idx_r;

  logic               found_r;
  logic [IDX_W-1:0]   found_idx_r;
  logic [RANK_W-1:0]  found_rank_r;
  logic               best_vld_r;
  logic [IDX_W-1:0]   best_idx_r;
  logic [RANK_W-1:0]  best_rank_r;
  logic               free_vld_r;
  logic [IDX_W-1:0]   free_idx_r;

  lfcd_pkg::result_t  res_r;

  logic               re;
  logic               we;
  logic [IDX_W-1:0]   waddr;
  logic [WORD_W-1:0]  wdata;
  logic [WORD_W-1:0]  rdata;
  logic [KEY_W-1:0]   key_rd;
  logic [RANK_W-1:0]  rank_rd;
  logic [RANK_W-1:0]  adj;
  logic               chk_v;
  logic               chk_match;
  logic               wb_en;
  logic [CNT_W-1:0]   cap_eff;
  logic [CMP_W-1:0]   cap_ext;
  logic               in_fire;
  logic               dec_evict;
  logic               dec_store;
  logic [IDX_W-1:0]   dec_tgt;

  assign cap_ext = CMP_W'(cfg.capacity);
  assign cap_eff = (cap_ext > CMP_W'(ENTRIES)) ? CNT_W'(ENTRIES) : CNT_W'(cap_ext);

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign res_valid = (state_r == ST_DONE);
  assign res       = res_r;

  assign re      = (state_r == ST_SCAN) && !rd_done_r;
  assign key_rd  = rdata[WORD_W-1:RANK_W];
  assign rank_rd = rdata[RANK_W-1:0];
  assign chk_v   = valid_r[chk_idx_r];
  assign chk_match = chk_vld_r && chk_v && (key_rd == key_r);

  // rank as it stands once the previous item's update is applied
  always_comb begin
    adj = rank_rd;
    unique case (pend_r.kind)
      PK_NONE:  adj = rank_rd;
      PK_ALL:   adj = rank_rd + RANK_W'(1);
      PK_BELOW: begin
        if (rank_rd < pend_r.thr) begin
          adj = rank_rd + RANK_W'(1);
        end
      end
      default:  adj = rank_rd;
    endcase
    if (pend_r.kind != PK_NONE && chk_idx_r == pend_r.slot) begin
      adj = '0;
    end
  end

  assign wb_en = chk_vld_r && chk_v && (pend_r.kind != PK_NONE);

  assign dec_evict = (live_r >= cap_eff) && (live_r != '0) && best_vld_r;
  assign dec_store = dec_evict || free_vld_r;
  assign dec_tgt   = dec_evict ? best_idx_r : free_idx_r;

  always_comb begin
    if (state_r == ST_DECIDE) begin
      we    = !found_r && dec_store;
      waddr = dec_tgt;
      wdata = {key_r, RANK_W'(0)};
    end else begin
      we    = wb_en;
      waddr = chk_idx_r;
      wdata = {key_rd, adj};
    end
  end

  lfcd_entry_ram #(
    .DEPTH  (ENTRIES),
    .WIDTH  (WORD_W),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (rd_idx_r),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      live_r      <= '0;
      pend_r.kind <= PK_NONE;
      chk_vld_r   <= 1'b0;
      rd_done_r   <= 1'b1;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            key_r      <= {in_host_tag[TAG_W-1:0], in_path_tag[TAG_W-1:0], in_server_port};
            rd_idx_r   <= '0;
            rd_done_r  <= 1'b0;
            chk_vld_r  <= 1'b0;
            found_r    <= 1'b0;
            best_vld_r <= 1'b0;
            free_vld_r <= 1'b0;
            if (cap_eff == '0) begin
              res_r   <= '0;
              state_r <= ST_DONE;
            end else begin
              state_r <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          // reads are done by the last check, so this drops the check flag there
          chk_vld_r <= re;
          chk_idx_r <= rd_idx_r;
          if (re) begin
            rd_idx_r <= rd_idx_r + IDX_W'(1);
            if (rd_idx_r == LAST_IDX) begin
              rd_done_r <= 1'b1;
            end
          end
          if (chk_vld_r) begin
            if (chk_match && !found_r) begin
              found_r      <= 1'b1;
              found_idx_r  <= chk_idx_r;
              found_rank_r <= adj;
            end
            if (chk_v && (!best_vld_r || adj > best_rank_r)) begin
              best_vld_r  <= 1'b1;
              best_idx_r  <= chk_idx_r;
              best_rank_r <= adj;
            end
            if (!chk_v && !free_vld_r) begin
              free_vld_r <= 1'b1;
              free_idx_r <= chk_idx_r;
            end
            if (chk_idx_r == LAST_IDX) begin
              pend_r.kind <= PK_NONE;
              state_r     <= ST_DECIDE;
            end
          end
        end
        ST_DECIDE: begin
          state_r <= ST_DONE;
          if (found_r) begin
            res_r.hit     <= 1'b1;
            res_r.slot    <= lfcd_pkg::SLOT_W'(found_idx_r);
            res_r.evicted <= 1'b0;
            res_r.stored  <= 1'b1;
            if (cfg.replace_mode == lfcd_pkg::MODE_LRU) begin
              pend_r.kind <= PK_BELOW;
              pend_r.slot <= found_idx_r;
              pend_r.thr  <= found_rank_r;
            end else begin
              pend_r.kind <= PK_NONE;
            end
          end else if (dec_store) begin
            valid_r[dec_tgt] <= 1'b1;
            if (!dec_evict) begin
              live_r <= live_r + CNT_W'(1);
            end
            pend_r.kind   <= PK_ALL;
            pend_r.slot   <= dec_tgt;
            res_r.hit     <= 1'b0;
            res_r.slot    <= lfcd_pkg::SLOT_W'(dec_tgt);
            res_r.evicted <= dec_evict;
            res_r.stored  <= 1'b1;
          end else begin
            pend_r.kind <= PK_NONE;
            res_r       <= '0;
          end
        end
        ST_DONE: begin
          if (res_ready) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= CNT_W'(ENTRIES))
    else $error("live count above entry count");

  a_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (we && re) |-> (waddr != rd_idx_r))
    else $error("write-back collides with scan read");

  a_victim_seen: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DECIDE && !found_r && live_r != '0) |-> best_vld_r)
    else $error("live entries but no victim candidate");

  a_cap_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && cap_eff == '0) |=> (state_r == ST_DONE && !res_r.stored))
    else $error("zero capacity item not passed straight through");

endmodule

/* rtl/lru_fifo_cache_directory.sv */
// Fully associative LRU/FIFO cache directory: config registers and result register.
//
// Each accepted item (host tag, path tag, port) is looked up against all
// ENTRIES slots by a sequential scan of the entry memory, one entry per cycle
// through its single read port; the recency update of an item is carried over
// and folded into the next item's scan as each entry is read and written back.
// Each item is scanned in full before the next one is accepted; when the
// capacity register is zero, the item passes straight to the result with no
// scan. The result waits in an output register, so the next item can be
// accepted while it is still pending. Configuration writes are taken in every
// cycle and must only be issued while no item is in flight.
module lru_fifo_cache_directory #(
  parameter int ENTRIES  = lfcd_pkg::ENTRIES_DEF,
  parameter int TAG_BITS = lfcd_pkg::TAG_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,

  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lfcd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lfcd_pkg::CFG_DATA_W-1:0] cfg_wdata,

  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [lfcd_pkg::HOST_W-1:0]     in_host_tag,
  input  logic [lfcd_pkg::PATH_W-1:0]     in_path_tag,
  input  logic [lfcd_pkg::PORT_W-1:0]     in_server_port,

  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_hit,
  output logic [lfcd_pkg::SLOT_W-1:0]     out_slot,
  output logic                            out_evicted,
  output logic                            out_stored
);

  lfcd_pkg::cfg_t    cfg_r;
  lfcd_pkg::result_t res;
  lfcd_pkg::result_t out_r;
  logic              res_valid;
  logic              res_ready;
  logic              out_valid_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.replace_mode <= lfcd_pkg::MODE_LRU;
      cfg_r.capacity     <= lfcd_pkg::CAPACITY_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lfcd_pkg::REG_REPLACE_MODE: cfg_r.replace_mode <= cfg_wdata[0];
        lfcd_pkg::REG_CAPACITY:     cfg_r.capacity     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  lfcd_ctrl #(
    .ENTRIES  (ENTRIES),
    .TAG_BITS (TAG_BITS)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_host_tag    (in_host_tag),
    .in_path_tag    (in_path_tag),
    .in_server_port (in_server_port),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .res            (res)
  );

  // load a new item when the register is empty or being drained
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_hit     = out_r.hit;
  assign out_slot    = out_r.slot;
  assign out_evicted = out_r.evicted;
  assign out_stored  = out_r.stored;

endmodule

/* verif/tb_lru_fifo_cache_directory.sv */
// Self-checking testbench for the LRU/FIFO cache directory: directed and random lookups.

class directory_scoreboard;
  // Shadow copy of the directory and its registers
  bit                            slot_live [lfcd_pkg::ENTRIES_DEF];
  logic [lfcd_pkg::HOST_W-1:0]   slot_host [lfcd_pkg::ENTRIES_DEF];
  logic [lfcd_pkg::PATH_W-1:0]   slot_path [lfcd_pkg::ENTRIES_DEF];
  logic [lfcd_pkg::PORT_W-1:0]   slot_port [lfcd_pkg::ENTRIES_DEF];
  logic [lfcd_pkg::SLOT_W-1:0]   slot_age  [lfcd_pkg::ENTRIES_DEF];
  logic [lfcd_pkg::CAP_W-1:0]    occupancy;
  logic                          mode;
  logic [lfcd_pkg::CAP_W-1:0]    capacity;

  lfcd_pkg::result_t expected_lookups[$];
  int errors;

  function new();
    for (int i = 0; i < lfcd_pkg::ENTRIES_DEF; i++) begin
      slot_live[i] = 1'b0;
      slot_host[i] = '0;
      slot_path[i] = '0;
      slot_port[i] = '0;
      slot_age[i]  = '0;
    end
    occupancy = '0;
    mode      = lfcd_pkg::MODE_LRU;
    capacity  = lfcd_pkg::CAPACITY_RST;
    errors    = 0;
  endfunction

  task report_mismatch(string msg);
    errors++;
    $display("mismatch: %s", msg);
  endtask

  function int pending_count();
    return expected_lookups.size();
  endfunction

  function void write_reg(logic [lfcd_pkg::CFG_IDX_W-1:0] idx,
                          logic [lfcd_pkg::CFG_DATA_W-1:0] data);
    if (idx == lfcd_pkg::REG_REPLACE_MODE) mode = data[0];
    else if (idx == lfcd_pkg::REG_CAPACITY) capacity = data[lfcd_pkg::CAP_W-1:0];
  endfunction

  // Predict the lookup result and update the shadow directory
  function void note_access(logic [lfcd_pkg::HOST_W-1:0] host,
                            logic [lfcd_pkg::PATH_W-1:0] path,
                            logic [lfcd_pkg::PORT_W-1:0] port);
    lfcd_pkg::result_t res;
    int found;
    int victim;
    int lim;
    logic [lfcd_pkg::SLOT_W-1:0] hit_age;
    logic [lfcd_pkg::SLOT_W-1:0] top_age;
    res     = '0;
    found   = -1;
    victim  = -1;
    top_age = '0;
    lim = (capacity > lfcd_pkg::ENTRIES_DEF) ? lfcd_pkg::ENTRIES_DEF : int'(capacity);
    if (lim == 0) begin
      expected_lookups.push_back(res);
      return;
    end
    for (int i = 0; i < lfcd_pkg::ENTRIES_DEF; i++)
      if (found < 0 && slot_live[i] && slot_host[i] == host && slot_path[i] == path &&
          slot_port[i] == port)
        found = i;
    if (found >= 0) begin
      if (mode == lfcd_pkg::MODE_LRU) begin
        hit_age = slot_age[found];
        for (int i = 0; i < lfcd_pkg::ENTRIES_DEF; i++)
          if (slot_live[i] && slot_age[i] < hit_age) slot_age[i]++;
        slot_age[found] = '0;
      end
      res.hit    = 1'b1;
      res.slot   = lfcd_pkg::SLOT_W'(found);
      res.stored = 1'b1;
      expected_lookups.push_back(res);
      return;
    end
    // Full (or over-full after a capacity drop): drop the oldest-ranked entry
    if (int'(occupancy) >= lim && occupancy > 0) begin
      for (int i = 0; i < lfcd_pkg::ENTRIES_DEF; i++)
        if (slot_live[i] && (victim < 0 || slot_age[i] > top_age)) begin
          victim  = i;
          top_age = slot_age[i];
        end
      if (victim >= 0) begin
        slot_live[victim] = 1'b0;
        occupancy--;
        res.evicted = 1'b1;
      end
    end
    if (victim < 0)
      for (int i = 0; i < lfcd_pkg::ENTRIES_DEF; i++)
        if (victim < 0 && !slot_live[i]) victim = i;
    if (victim < 0) begin
      expected_lookups.push_back('0);
      return;
    end
    for (int i = 0; i < lfcd_pkg::ENTRIES_DEF; i++)
      if (slot_live[i]) slot_age[i]++;
    slot_live[victim] = 1'b1;
    slot_host[victim] = host;
    slot_path[victim] = path;
    slot_port[victim] = port;
    slot_age[victim]  = '0;
    occupancy++;
    res.slot   = lfcd_pkg::SLOT_W'(victim);
    res.stored = 1'b1;
    expected_lookups.push_back(res);
  endfunction

  task check_result(lfcd_pkg::result_t got);
    lfcd_pkg::result_t want;
    if (expected_lookups.size() == 0) begin
      report_mismatch($sformatf("result with nothing pending: %p", got));
      return;
    end
    want = expected_lookups.pop_front();
    if (got.hit !== want.hit)
      report_mismatch($sformatf("hit got %b want %b", got.hit, want.hit));
    if (got.slot !== want.slot)
      report_mismatch($sformatf("slot got %0d want %0d", got.slot, want.slot));
    if (got.evicted !== want.evicted)
      report_mismatch($sformatf("evicted got %b want %b", got.evicted, want.evicted));
    if (got.stored !== want.stored)
      report_mismatch($sformatf("stored got %b want %b", got.stored, want.stored));
  endtask
endclass

module tb_lru_fifo_cache_directory;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = lfcd_pkg::ENTRIES_DEF + 8;
  localparam int PHASE_ITEMS   = 48;
  localparam int SWAP_AT       = 215;
  localparam int CALM_AT       = 430;

  typedef struct packed {
    logic [lfcd_pkg::HOST_W-1:0] host;
    logic [lfcd_pkg::PATH_W-1:0] path;
    logic [lfcd_pkg::PORT_W-1:0] port;
  } key_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [lfcd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [lfcd_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [lfcd_pkg::HOST_W-1:0] in_host_tag = '0;
  logic [lfcd_pkg::PATH_W-1:0] in_path_tag = '0;
  logic [lfcd_pkg::PORT_W-1:0] in_server_port = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_hit;
  logic [lfcd_pkg::SLOT_W-1:0] out_slot;
  logic out_evicted;
  logic out_stored;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int items_sent = 0;
  key_t key_pool[$];
  directory_scoreboard sb;

  lru_fifo_cache_directory DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_host_tag    (in_host_tag),
    .in_path_tag    (in_path_tag),
    .in_server_port (in_server_port),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hit        (out_hit),
    .out_slot       (out_slot),
    .out_evicted    (out_evicted),
    .out_stored     (out_stored)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Every handshake is observed here, on pre-edge values
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_wdata);
      if (in_valid && in_ready) sb.note_access(in_host_tag, in_path_tag, in_server_port);
      if (out_valid && out_ready)
        sb.check_result(lfcd_pkg::result_t'({out_hit, out_slot, out_evicted, out_stored}));
    end
  end

  function automatic key_t random_key();
    key_t k;
    int pick;
    pick = $urandom_range(0, 9);
    k.host = (pick == 0) ? '0 : (pick == 1) ? '1 : lfcd_pkg::HOST_W'($urandom());
    pick = $urandom_range(0, 9);
    k.path = (pick == 0) ? '0 : (pick == 1) ? '1 : lfcd_pkg::PATH_W'($urandom());
    pick = $urandom_range(0, 9);
    k.port = (pick == 0) ? '0 : (pick == 1) ? '1 :
             lfcd_pkg::PORT_W'($urandom_range(0, 65535));
    return k;
  endfunction

  function automatic key_t mk_key(logic [lfcd_pkg::HOST_W-1:0] host,
                                  logic [lfcd_pkg::PATH_W-1:0] path,
                                  logic [lfcd_pkg::PORT_W-1:0] port);
    key_t k;
    k.host = host;
    k.path = path;
    k.port = port;
    return k;
  endfunction

  // Mix fresh keys with near misses that differ from a pool key in one bit
  function automatic void build_pool(int n);
    key_t k;
    key_pool.delete();
    for (int i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(0, 3) == 0) begin
        k = key_pool[$urandom_range(0, i - 1)];
        case ($urandom_range(0, 2))
          0: k.host[$urandom_range(0, lfcd_pkg::HOST_W - 1)] ^= 1'b1;
          1: k.path[$urandom_range(0, lfcd_pkg::PATH_W - 1)] ^= 1'b1;
          default: k.port[$urandom_range(0, lfcd_pkg::PORT_W - 1)] ^= 1'b1;
        endcase
      end else begin
        k = random_key();
      end
      key_pool.push_back(k);
    end
  endfunction

  task automatic send_key(key_t k);
    if (items_sent < SWAP_AT) begin
      send_idle_pct = 38;
      recv_idle_pct = 63;
    end else if (items_sent < CALM_AT) begin
      send_idle_pct = 63;
      recv_idle_pct = 38;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_host_tag    <= k.host;
    in_path_tag    <= k.path;
    in_server_port <= k.port;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // Send a run of items one after another, then drop valid
  task automatic send_burst(key_t keys[$]);
    foreach (keys[i]) send_key(keys[i]);
    in_valid <= 1'b0;
  endtask

  // Let the last accepted item reach the scoreboard before counting
  task automatic wait_idle();
    @(posedge clk);
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(logic mode, logic [lfcd_pkg::CAP_W-1:0] cap);
    logic [lfcd_pkg::CFG_IDX_W-1:0] idx [2];
    logic [lfcd_pkg::CFG_DATA_W-1:0] data [2];
    idx[0]  = lfcd_pkg::REG_REPLACE_MODE;
    data[0] = {(lfcd_pkg::CFG_DATA_W - 1)'($urandom_range(0, 15)), mode};
    idx[1]  = lfcd_pkg::REG_CAPACITY;
    data[1] = cap;
    wait_idle();
    for (int i = 0; i < 2; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= data[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(logic mode, logic [lfcd_pkg::CAP_W-1:0] cap);
    key_t keys[$];
    int lim;
    write_config(mode, cap);
    lim = (cap > lfcd_pkg::ENTRIES_DEF) ? lfcd_pkg::ENTRIES_DEF : int'(cap);
    build_pool($urandom_range(lim / 2 + 2, lim + 8));
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if ($urandom_range(0, 99) < 85)
        keys.push_back(key_pool[$urandom_range(0, key_pool.size() - 1)]);
      else
        keys.push_back(random_key());
    end
    send_burst(keys);
  endtask

  initial begin
    key_t d[10];
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    d[0] = mk_key('0, '0, '0);
    d[1] = mk_key('1, '1, '1);
    d[2] = mk_key('0, '0, 16'd1);
    d[3] = mk_key('0, 32'd1, '0);
    d[4] = mk_key(32'd1, '0, '0);
    for (int i = 5; i < 10; i++) d[i] = random_key();

    // Reset settings: fill lowest free slots, then hits reorder recency
    send_burst('{d[0], d[1], d[2], d[3], d[4], d[0], d[1], d[4], d[3]});
    // Capacity at live count: misses evict the least recent entry
    write_config(lfcd_pkg::MODE_LRU, 5'd5);
    send_burst('{d[5], d[2], d[6]});
    // FIFO: hits leave order alone, misses evict the oldest insert
    write_config(lfcd_pkg::MODE_FIFO, 5'd5);
    send_burst('{d[0], d[7], d[8]});
    // Caching disabled while entries remain
    write_config(lfcd_pkg::MODE_LRU, 5'd0);
    send_burst('{d[0], d[7]});
    // Capacity beyond the entry count saturates
    write_config(lfcd_pkg::MODE_FIFO, 5'd31);
    send_burst('{d[7], d[9]});

    run_phase(lfcd_pkg::MODE_LRU, 5'd16);
    run_phase(lfcd_pkg::MODE_FIFO, 5'd16);
    run_phase(lfcd_pkg::MODE_LRU, 5'd3);
    run_phase(lfcd_pkg::MODE_FIFO, 5'd1);
    run_phase(lfcd_pkg::MODE_LRU, 5'd0);
    run_phase(lfcd_pkg::MODE_FIFO, 5'd31);
    run_phase(lfcd_pkg::MODE_LRU, 5'd17);
    run_phase(lfcd_pkg::MODE_FIFO, 5'd0);
    run_phase(lfcd_pkg::MODE_LRU, 5'd8);
    run_phase(lfcd_pkg::MODE_FIFO, 5'd5);
    for (int p = 0; p < 3; p++)
      run_phase(1'($urandom_range(0, 1)), lfcd_pkg::CAP_W'($urandom_range(0, 31)));

    wait_idle();
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end
endmodule

/* sim.f */
rtl/lfcd_pkg.sv
rtl/lfcd_entry_ram.sv
rtl/lfcd_ctrl.sv
rtl/lru_fifo_cache_directory.sv
verif/tb_lru_fifo_cache_directory.sv
